[hw/rtl/lrukv_pkg.sv]
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared types and constants for the LRU key-value cache: payload structs,
// operation codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lrukv_pkg;

  localparam int KEY_FIELD_W = 64;
  localparam int VAL_FIELD_W = 64;
  localparam int OCC_W       = 5;
  localparam int CAP_W       = 5;

  // Operation codes carried in the cmd field
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                   cmd;
    logic [KEY_FIELD_W-1:0] lookup_key;
    logic [VAL_FIELD_W-1:0] write_value;
  } lrukv_in_t;

  typedef struct packed {
    logic                   hit;
    logic [VAL_FIELD_W-1:0] read_value;
    logic                   evicted;
    logic [OCC_W-1:0]       occupancy;
  } lrukv_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_FINISH
  } lrukv_state_t;

  // Controller to datapath
  typedef struct packed {
    logic scan_start;  // capture the input item, restart the scan
    logic scan_en;     // read one key slot, advance the scan index
    logic update;      // commit the lookup outcome to the stores
    logic load_out;    // move the result into the output register
  } lrukv_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;   // the scan index points at the last slot
    logic out_free;    // output register empty or draining this cycle
  } lrukv_status_t;

endpackage

[hw/rtl/lrukv_ram.sv]
// ----------------------------------------------------------------------------
// lrukv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lrukv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/lrukv_ctrl.sv]
// ----------------------------------------------------------------------------
// lrukv_ctrl
// Operation sequencer: accept, scan the key store, commit, deliver the result.
// ----------------------------------------------------------------------------
module lrukv_ctrl
  import lrukv_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lrukv_status_t status,
  output lrukv_cmd_t    ctl
);

  lrukv_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall       = 1'b0;
        ctl.scan_start = in_valid;
      end
      ST_SCAN:   ctl.scan_en  = 1'b1;
      ST_DRAIN:  ctl          = '0;
      ST_UPDATE: ctl.update   = 1'b1;
      ST_FINISH: ctl.load_out = status.out_free;
      default:   ctl          = '0;
    endcase
  end

endmodule

[hw/rtl/lrukv_dp.sv]
// ----------------------------------------------------------------------------
// lrukv_dp
// Datapath: key/value RAMs, valid bits, recency ranks, lookup scan state,
// entry count and the output register.
// ----------------------------------------------------------------------------
module lrukv_dp
  import lrukv_pkg::*;
#(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lrukv_cmd_t       ctl,
  output lrukv_status_t    status,
  input  lrukv_in_t        in_data,
  input  logic [CAP_W-1:0] capacity,
  input  logic             out_stall,
  output logic             out_valid,
  output lrukv_out_t       out_data
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  // Operation registers
  logic                   cmd_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;

  // Scan state
  logic [IW-1:0] scan_idx_r;
  logic          cmp_vld_r;
  logic [IW-1:0] cmp_idx_r;
  logic          found_r, free_found_r, victim_found_r;
  logic [IW-1:0] found_idx_r, found_rank_r, free_idx_r, victim_idx_r;

  // Entry state
  logic          valid_r   [DEPTH];
  logic          valid_nxt [DEPTH];
  logic [IW-1:0] rank_r    [DEPTH];
  logic [IW-1:0] rank_nxt  [DEPTH];
  logic [CW-1:0] count_r;

  // Result staging
  logic res_hit_r, res_ev_r, res_get_hit_r;
  logic out_valid_r;
  lrukv_out_t out_r;

  // RAM ports
  logic [KEY_WIDTH-1:0]   key_rdata;
  logic [VALUE_WIDTH-1:0] val_rdata;

  // Commit decisions
  logic          is_put, evict_need;
  logic          age_en, set_en, key_we, val_we, cnt_inc, ev;
  logic [CW-1:0] age_limit;
  logic [IW-1:0] slot_idx;
  logic [CMPW-1:0] cnt_w, cap_w;

  // Per-slot probes at the compare stage
  logic cmp_valid, cmp_match, cmp_lru;

  lrukv_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (slot_idx),
    .wdata (key_r),
    .re    (ctl.scan_en),
    .raddr (scan_idx_r),
    .rdata (key_rdata)
  );

  lrukv_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (slot_idx),
    .wdata (val_r),
    .re    (ctl.update && found_r && (cmd_r == OP_GET)),
    .raddr (found_idx_r),
    .rdata (val_rdata)
  );

  // Capture and scan index
  always_ff @(posedge clk) begin
    if (ctl.scan_start) begin
      cmd_r <= in_data.cmd;
      key_r <= in_data.lookup_key[KEY_WIDTH-1:0];
      val_r <= in_data.write_value[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      cmp_vld_r  <= 1'b0;
      cmp_idx_r  <= '0;
    end else begin
      cmp_vld_r <= ctl.scan_en;
      cmp_idx_r <= scan_idx_r;
      if (ctl.scan_start) begin
        scan_idx_r <= '0;
      end else if (ctl.scan_en) begin
        scan_idx_r <= scan_idx_r + IW'(1);
      end
    end
  end

  assign cmp_valid = valid_r[cmp_idx_r];
  assign cmp_match = cmp_vld_r && cmp_valid && (key_rdata == key_r);
  assign cmp_lru   = cmp_vld_r && cmp_valid &&
                     ((CW'(rank_r[cmp_idx_r]) + CW'(1)) == count_r);

  // Record the first hit, first free slot and the least recent slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r        <= 1'b0;
      free_found_r   <= 1'b0;
      victim_found_r <= 1'b0;
    end else if (ctl.scan_start) begin
      found_r        <= 1'b0;
      free_found_r   <= 1'b0;
      victim_found_r <= 1'b0;
    end else begin
      if (cmp_match && !found_r) begin
        found_r      <= 1'b1;
        found_idx_r  <= cmp_idx_r;
        found_rank_r <= rank_r[cmp_idx_r];
      end
      if (cmp_vld_r && !cmp_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
      if (cmp_lru && !victim_found_r) begin
        victim_found_r <= 1'b1;
        victim_idx_r   <= cmp_idx_r;
      end
    end
  end

  // Commit decision
  assign is_put     = (cmd_r == OP_PUT);
  assign cnt_w      = CMPW'(count_r);
  assign cap_w      = CMPW'(capacity);
  assign evict_need = (cnt_w >= cap_w) || (count_r == CW'(DEPTH));

  always_comb begin
    age_en    = 1'b0;
    set_en    = 1'b0;
    key_we    = 1'b0;
    val_we    = 1'b0;
    cnt_inc   = 1'b0;
    ev        = 1'b0;
    age_limit = count_r;
    slot_idx  = free_idx_r;
    if (ctl.update) begin
      if (found_r) begin
        age_en    = 1'b1;
        age_limit = CW'(found_rank_r);
        set_en    = 1'b1;
        slot_idx  = found_idx_r;
        val_we    = is_put;
      end else if (is_put) begin
        if (evict_need) begin
          ev = 1'b1;
          // Reuse the least recent slot; with nothing stored the new
          // entry leaves at once
          if (count_r != '0) begin
            age_en   = 1'b1;
            set_en   = 1'b1;
            slot_idx = victim_idx_r;
            key_we   = 1'b1;
            val_we   = 1'b1;
          end
        end else begin
          age_en  = 1'b1;
          set_en  = 1'b1;
          key_we  = 1'b1;
          val_we  = 1'b1;
          cnt_inc = 1'b1;
        end
      end
    end
  end

  // Age every valid entry more recent than the limit, then mark the slot
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_nxt[i] = valid_r[i];
      rank_nxt[i]  = rank_r[i];
      if (age_en && valid_r[i] && (CW'(rank_r[i]) < age_limit)) begin
        rank_nxt[i] = rank_r[i] + IW'(1);
      end
      if (set_en && (slot_idx == IW'(i))) begin
        valid_nxt[i] = 1'b1;
        rank_nxt[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
      count_r <= '0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        valid_r[i] <= valid_nxt[i];
        rank_r[i]  <= rank_nxt[i];
      end
      if (cnt_inc) count_r <= count_r + CW'(1);
    end
  end

  // Result staging and output register
  always_ff @(posedge clk) begin
    if (ctl.update) begin
      res_hit_r     <= found_r;
      res_ev_r      <= ev;
      res_get_hit_r <= found_r && !is_put;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_r.hit        <= res_hit_r;
      out_r.read_value <= res_get_hit_r ? VAL_FIELD_W'(val_rdata) : '0;
      out_r.evicted    <= res_ev_r;
      out_r.occupancy  <= OCC_W'(count_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_r;
  assign status.scan_last = (scan_idx_r == IW'(DEPTH - 1));
  assign status.out_free  = !out_valid_r || !out_stall;

endmodule

[hw/rtl/lru_key_value_cache_top.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each operation (get or put) walks the key RAM one slot per cycle through its
// single read port, then finishes the last compare, commits the update and
// loads the result into the output register. The block is back in idle in
// the cycle the result appears. One operation is in flight at a time; the
// next item is taken as soon as the previous result is in the output
// register, even while that result still waits under out_stall; the following
// operation then holds in its load step until the waiting result has left. A
// get returns hit and the stored value (zero on a miss); a put updates or
// inserts and reports whether it evicted the least recent entry. occupancy is
// the entry count after the operation, in its low 5 bits. The capacity
// register resets to 0 (nothing kept) and is not clamped, but no more than
// DEPTH entries are kept; write it only while the block is idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top
  import lrukv_pkg::*;
#(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  // Input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  lrukv_in_t        in_data,
  // Result channel
  output logic             out_valid,
  input  logic             out_stall,
  output lrukv_out_t       out_data,
  // Configuration
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  lrukv_cmd_t       ctl;
  lrukv_status_t    status;
  logic [CAP_W-1:0] capacity_r;

  // Capacity register: hold until written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  // Sequencer: drive the scan, commit and result load
  lrukv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ctl      (ctl)
  );

  // Storage, lookup and output register
  lrukv_dp #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .status    (status),
    .in_data   (in_data),
    .capacity  (capacity_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // An accepted item blocks further input transfers while it is worked on
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("input taken again right after a transfer");

  // A key that was present is never evicted by the same operation
  a_hit_no_evict: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.hit && out_data.evicted)
  ) else $error("result reports both hit and eviction");

  // Value is zero unless the key hit
  a_miss_zero_value: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> (out_data.read_value == '0)
  ) else $error("nonzero read value on a miss");

  // A result is loaded only once the scan has ended
  a_load_after_scan: assert property (
    @(posedge clk) disable iff (!rst_n)
    ctl.load_out |-> !ctl.scan_en && !ctl.scan_start
  ) else $error("result load overlaps a scan");

endmodule
